// ===== hw/rtl/fa_row_pkg.sv =====
// Shared types, widths and constants of the flash attention row core.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fa_row_pkg;

    // Store geometry
    localparam int MAX_KEYS = 256;
    localparam int HEAD_DIM = 64;
    localparam int KEY_TILE = 16;
    localparam int KEY_AW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int HD_AW    = (HEAD_DIM > 1) ? $clog2(HEAD_DIM) : 1;
    localparam int TILE_AW  = (KEY_TILE > 1) ? $clog2(KEY_TILE) : 1;

    // Beat field widths
    localparam int CMD_W = 2;
    localparam int ROW_W = 8;
    localparam int COL_W = 6;
    localparam int VAL_W = 16;

    // Configuration register widths and indexes
    localparam int KC_W       = 9;
    localparam int HD_W       = 7;
    localparam int SCALE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_DIM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAUSAL      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_SCALE = 2'd3;

    // Commands
    localparam logic [CMD_W-1:0] CMD_LOAD_Q = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_K = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_V = 2'd2;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd3;

    // Datapath widths
    localparam int ACC_W   = 40;
    localparam int SUM_W   = 32;
    localparam int SCORE_W = 32;
    localparam int DOT_W   = 38;
    localparam int EXP_W   = 17;
    localparam int MUL_AW  = 41;
    localparam int MUL_BW  = 18;
    localparam int MUL_PW  = MUL_AW + MUL_BW;
    localparam int SCORE_SH = 24;
    localparam int FRAC_SH  = 16;
    localparam int LOG2E_Q16 = 94548;

    // Request to and response from the divider
    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] dividend;
        logic [SUM_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                    busy;
        logic signed [VAL_W-1:0] quot;
    } t_div_rsp;

    // 2^(-i/16) in unsigned Q1.16, i = 0..16
    function automatic logic [EXP_W-1:0] exp2_tab(input logic [4:0] i);
        logic [EXP_W-1:0] t;
        case (i)
            5'd0:  t = 17'd65536;
            5'd1:  t = 17'd62757;
            5'd2:  t = 17'd60097;
            5'd3:  t = 17'd57549;
            5'd4:  t = 17'd55109;
            5'd5:  t = 17'd52773;
            5'd6:  t = 17'd50535;
            5'd7:  t = 17'd48393;
            5'd8:  t = 17'd46341;
            5'd9:  t = 17'd44376;
            5'd10: t = 17'd42495;
            5'd11: t = 17'd40693;
            5'd12: t = 17'd38968;
            5'd13: t = 17'd37316;
            5'd14: t = 17'd35734;
            5'd15: t = 17'd34219;
            default: t = 17'd32768;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fa_row_in_if.sv =====
// Input channel of the flash attention row core: one load or compute beat.
// Depends on fa_row_pkg for the field widths.
`default_nettype none

interface fa_row_in_if import fa_row_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [ROW_W-1:0]        row_index;
    logic [COL_W-1:0]        col_index;
    logic signed [VAL_W-1:0] in_value;

    modport source (output valid, output cmd, output row_index, output col_index,
                    output in_value, input ready);
    modport sink   (input valid, input cmd, input row_index, input col_index,
                    input in_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fa_row_out_if.sv =====
// Output channel of the flash attention row core: one output element per beat.
// Depends on fa_row_pkg for the field widths.
`default_nettype none

interface fa_row_out_if import fa_row_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [COL_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    out_last;

    modport source (output valid, output out_col, output out_value, output out_last,
                    input ready);
    modport sink   (input valid, input out_col, input out_value, input out_last,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fa_row_mul.sv =====
// Shared signed multiplier of the row core, product registered.
// Depends on fa_row_pkg for operand widths.
`default_nettype none

module fa_row_mul import fa_row_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_AW-1:0] i_a,
    input  logic signed [MUL_BW-1:0] i_b,
    output logic signed [MUL_PW-1:0] o_p
);

    logic signed [MUL_PW-1:0] r_p;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_p <= MUL_PW'(i_a) * MUL_PW'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== hw/rtl/fa_row_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating toward zero and
// saturating to Q4.12. Depends on fa_row_pkg for widths and request types.
`default_nettype none

module fa_row_div import fa_row_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(ACC_W + 1);
    localparam logic [ACC_W-1:0] SAT_POS = ACC_W'(2 ** (VAL_W - 1) - 1);
    localparam logic [ACC_W-1:0] SAT_NEG = ACC_W'(2 ** (VAL_W - 1));

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_div;
    logic [ACC_W-1:0] r_q;
    logic             r_neg;

    logic [SUM_W:0]          sh;
    logic [SUM_W:0]          diff;
    logic                    ge;
    logic signed [VAL_W-1:0] sat;

    // One trial subtraction a step
    always_comb begin
        sh   = {r_rem, r_q[ACC_W-1]};
        diff = sh - {1'b0, r_div};
        ge   = (sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ACC_W);
            r_rem  <= '0;
            r_div  <= i_req.divisor;
            r_neg  <= i_req.dividend[ACC_W-1];
            r_q    <= i_req.dividend[ACC_W-1] ? ACC_W'(-i_req.dividend)
                                              : ACC_W'(i_req.dividend);
        end else if (r_busy) begin
            r_rem <= ge ? diff[SUM_W-1:0] : sh[SUM_W-1:0];
            r_q   <= {r_q[ACC_W-2:0], ge};
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Apply the sign and clamp; a zero divisor gives zero
    always_comb begin
        if (r_div == '0) begin
            sat = '0;
        end else if (r_neg) begin
            sat = (r_q > SAT_NEG) ? -VAL_W'(signed'(SAT_NEG[VAL_W-1:0]))
                                  : VAL_W'(-r_q[VAL_W-1:0]);
        end else begin
            sat = (r_q > SAT_POS) ? signed'(SAT_POS[VAL_W-1:0]) : signed'(r_q[VAL_W-1:0]);
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = sat;

endmodule

`default_nettype wire

// ===== hw/rtl/flash_attention_row_core.sv =====
// One query row of scaled dot-product attention with online softmax. Load beats
// (query, key or value element) are taken one per cycle while the core is idle.
// A compute beat walks the keys in tiles of KEY_TILE through one shared
// multiplier: each unmasked key gets its score from a dot product and later its
// exponential and value accumulation; a tile whose maximum rises adds a
// rescaling pass. A clearing sweep of head_dim entries opens the compute and each
// output element then goes through the 40-step divider. The block takes no beat
// from compute start until the last output element is in the output register.
// Depends on fa_row_pkg, fa_row_in_if, fa_row_out_if, fa_row_mul, fa_row_div.
`default_nettype none

module flash_attention_row_core import fa_row_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fa_row_in_if.sink             i_in,
    fa_row_out_if.source          o_out
);

    typedef enum logic [22:0] {
        S_IDLE      = 23'h000001,
        S_CLEAR     = 23'h000002,
        S_TILE      = 23'h000004,
        S_KEY       = 23'h000008,
        S_STREAM    = 23'h000010,
        S_DRAIN     = 23'h000020,
        S_SCORE_M   = 23'h000040,
        S_SCORE_W   = 23'h000080,
        S_TMAX      = 23'h000100,
        S_EXP1      = 23'h000200,
        S_EXP2      = 23'h000400,
        S_EXP3      = 23'h000800,
        S_EXP4      = 23'h001000,
        S_RSUM_M    = 23'h002000,
        S_RSUM_W    = 23'h004000,
        S_PSTART    = 23'h008000,
        S_PKEY      = 23'h010000,
        S_PSCORE    = 23'h020000,
        S_PACC      = 23'h040000,
        S_NEXT_TILE = 23'h080000,
        S_ORD       = 23'h100000,
        S_OLAT      = 23'h200000,
        S_ODIV      = 23'h400000
    } t_state;

    typedef enum logic [1:0] {
        OP_DOT  = 2'd0,
        OP_RESC = 2'd1,
        OP_PV   = 2'd2
    } t_op;

    localparam logic signed [SCORE_W-1:0] MAX_INIT = {1'b1, {(SCORE_W-1){1'b0}}};

    // Configuration registers
    logic [KC_W-1:0]    r_key_count;
    logic [HD_W-1:0]    r_head_dim;
    logic               r_causal;
    logic [SCALE_W-1:0] r_scale;

    // Sequencer state
    t_state r_state;
    t_state r_ret;
    t_op    r_op;
    logic [ROW_W-1:0]          r_row;
    logic [KC_W-1:0]           r_kc;
    logic [HD_W-1:0]           r_hd;
    logic [KC_W-1:0]           r_j0;
    logic [KC_W-1:0]           r_j;
    logic [KC_W-1:0]           r_jend;
    logic [HD_AW-1:0]          r_k;
    logic [HD_AW-1:0]          r_k1;
    logic [HD_AW-1:0]          r_k2;
    logic                      r_v1;
    logic                      r_v2;
    logic                      r_any;
    logic signed [DOT_W-1:0]   r_dot;
    logic signed [SCORE_W-1:0] r_tmax;
    logic signed [SCORE_W-1:0] r_max;
    logic [SUM_W-1:0]          r_sum;
    logic signed [SCORE_W:0]   r_x;
    logic [EXP_W-1:0]          r_e;
    logic [4:0]                r_en;
    logic [3:0]                r_eidx;
    logic [11:0]               r_efr;

    // Output register
    logic                    r_ovalid;
    logic [COL_W-1:0]        r_ocol;
    logic signed [VAL_W-1:0] r_oval;
    logic                    r_olast;

    // Stores and their registered read data
    logic signed [VAL_W-1:0]   q_mem   [HEAD_DIM];
    logic signed [VAL_W-1:0]   key_mem [MAX_KEYS * HEAD_DIM];
    logic signed [VAL_W-1:0]   val_mem [MAX_KEYS * HEAD_DIM];
    logic signed [ACC_W-1:0]   acc_mem [HEAD_DIM];
    logic signed [SCORE_W-1:0] st_mem  [KEY_TILE];
    logic signed [VAL_W-1:0]   r_q_rd;
    logic signed [VAL_W-1:0]   r_key_rd;
    logic signed [VAL_W-1:0]   r_val_rd;
    logic signed [ACC_W-1:0]   r_acc_rd;
    logic signed [ACC_W-1:0]   r_acc_d;
    logic signed [SCORE_W-1:0] r_st_rd;

    // Combinational helpers
    logic                      in_acc;
    logic                      o_load;
    logic [KC_W-1:0]           kc_clamp;
    logic [HD_W-1:0]           hd_clamp;
    logic                      k_last;
    logic                      masked;
    logic [KC_W:0]             jsum;
    logic [KC_W-1:0]           jend;
    logic [KC_W-1:0]           j_off;
    logic [TILE_AW-1:0]        tidx;
    logic [KEY_AW+HD_AW-1:0]   kv_addr;
    logic [SCORE_W:0]          exp_m;
    logic [20:0]               exp_u;
    logic [EXP_W-1:0]          exp_t0;
    logic [EXP_W-1:0]          exp_t1;
    logic [EXP_W-1:0]          exp_val;
    logic signed [SCORE_W-1:0] score;
    logic                      acc_we;
    logic [HD_AW-1:0]          acc_waddr;
    logic signed [ACC_W-1:0]   acc_wdata;
    logic                      st_we;
    logic signed [MUL_AW-1:0]  mul_a;
    logic signed [MUL_BW-1:0]  mul_b;
    logic signed [MUL_PW-1:0]  mul_p;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    // Clamp the registers, find tile end and masking
    always_comb begin
        in_acc   = i_in.valid && i_in.ready;
        o_load   = (r_state == S_ODIV) && !div_rsp.busy && (!r_ovalid || o_out.ready);
        kc_clamp = (r_key_count == '0) ? KC_W'(1)
                 : ((r_key_count > KC_W'(MAX_KEYS)) ? KC_W'(MAX_KEYS) : r_key_count);
        hd_clamp = (r_head_dim == '0) ? HD_W'(1)
                 : ((r_head_dim > HD_W'(HEAD_DIM)) ? HD_W'(HEAD_DIM) : r_head_dim);
        k_last   = (HD_W'(r_k) == r_hd - HD_W'(1));
        masked   = r_causal && (r_j > KC_W'(r_row));
        jsum     = {1'b0, r_j0} + (KC_W+1)'(KEY_TILE);
        jend     = (jsum > {1'b0, r_kc}) ? r_kc : jsum[KC_W-1:0];
        j_off    = r_j - r_j0;
        tidx     = j_off[TILE_AW-1:0];
        kv_addr  = {r_j[KEY_AW-1:0], r_k};
        score    = mul_p[SCORE_SH+SCORE_W-1:SCORE_SH];
    end

    // Exponential helpers: magnitude of the argument and table reads
    always_comb begin
        exp_m   = r_x[SCORE_W] ? (SCORE_W+1)'(-r_x) : '0;
        exp_u   = mul_p[FRAC_SH+20:FRAC_SH];
        exp_t0  = exp2_tab({1'b0, r_eidx});
        exp_t1  = exp2_tab(5'({1'b0, r_eidx}) + 5'd1);
        exp_val = exp_t0 - EXP_W'(mul_p[23:12]);
    end

    // Select the multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_v1) begin
            case (r_op)
                OP_DOT: begin
                    mul_a = MUL_AW'(r_q_rd);
                    mul_b = MUL_BW'(r_key_rd);
                end
                OP_RESC: begin
                    mul_a = MUL_AW'(r_acc_rd);
                    mul_b = signed'(MUL_BW'(r_e));
                end
                OP_PV: begin
                    mul_a = signed'(MUL_AW'(r_e));
                    mul_b = MUL_BW'(r_val_rd);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end else begin
            case (r_state)
                S_SCORE_M: begin
                    mul_a = MUL_AW'(r_dot);
                    mul_b = signed'(MUL_BW'(r_scale));
                end
                S_EXP1: begin
                    mul_a = signed'(MUL_AW'(exp_m[19:0]));
                    mul_b = MUL_BW'(LOG2E_Q16);
                end
                S_EXP3: begin
                    mul_a = signed'(MUL_AW'(exp_t0 - exp_t1));
                    mul_b = signed'(MUL_BW'(r_efr));
                end
                S_RSUM_M: begin
                    mul_a = signed'(MUL_AW'(r_sum));
                    mul_b = signed'(MUL_BW'(r_e));
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    fa_row_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign div_req.start    = (r_state == S_OLAT);
    assign div_req.dividend = r_acc_rd;
    assign div_req.divisor  = r_sum;

    fa_row_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= KC_W'(256);
            r_head_dim  <= HD_W'(64);
            r_causal    <= 1'b0;
            r_scale     <= SCALE_W'(8192);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_COUNT:   r_key_count <= i_cfg_data[KC_W-1:0];
                CFG_HEAD_DIM:    r_head_dim  <= i_cfg_data[HD_W-1:0];
                CFG_CAUSAL:      r_causal    <= i_cfg_data[0];
                CFG_SCORE_SCALE: r_scale     <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Store writes on load beats
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.cmd == CMD_LOAD_Q) begin
            q_mem[i_in.col_index[HD_AW-1:0]] <= i_in.in_value;
        end
        if (in_acc && i_in.cmd == CMD_LOAD_K) begin
            key_mem[{i_in.row_index[KEY_AW-1:0], i_in.col_index[HD_AW-1:0]}] <= i_in.in_value;
        end
        if (in_acc && i_in.cmd == CMD_LOAD_V) begin
            val_mem[{i_in.row_index[KEY_AW-1:0], i_in.col_index[HD_AW-1:0]}] <= i_in.in_value;
        end
    end

    // Store reads, registered
    always_ff @(posedge i_clk) begin
        r_q_rd   <= q_mem[r_k];
        r_key_rd <= key_mem[kv_addr];
        r_val_rd <= val_mem[kv_addr];
        r_acc_rd <= acc_mem[r_k];
        r_acc_d  <= r_acc_rd;
        r_st_rd  <= st_mem[tidx];
    end

    // Accumulator write: clearing sweep or the tail of a stream; score store write
    always_comb begin
        acc_we    = (r_state == S_CLEAR) || (r_v2 && r_op != OP_DOT);
        acc_waddr = (r_state == S_CLEAR) ? r_k : r_k2;
        if (r_state == S_CLEAR) begin
            acc_wdata = '0;
        end else if (r_op == OP_RESC) begin
            acc_wdata = mul_p[FRAC_SH+ACC_W-1:FRAC_SH];
        end else begin
            acc_wdata = r_acc_d + ACC_W'(mul_p);
        end
        st_we = (r_state == S_SCORE_W);
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        if (st_we) begin
            st_mem[tidx] <= score;
        end
    end

    // Stream pipeline valid and index stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_STREAM);
            r_v2 <= r_v1;
        end
        r_k1 <= r_k;
        r_k2 <= r_k1;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_op     <= OP_DOT;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // drop the output beat once taken, unless a new one replaces it
            if (r_ovalid && o_out.ready && !o_load) begin
                r_ovalid <= 1'b0;
            end
            // fold the stream product into the dot product
            if (r_v2 && r_op == OP_DOT) begin
                r_dot <= r_dot + DOT_W'(mul_p);
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in.cmd == CMD_COMPUTE) begin
                        r_row   <= i_in.row_index;
                        r_kc    <= kc_clamp;
                        r_hd    <= hd_clamp;
                        r_k     <= '0;
                        r_state <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    if (k_last) begin
                        r_max   <= MAX_INIT;
                        r_sum   <= '0;
                        r_j0    <= '0;
                        r_state <= S_TILE;
                    end else begin
                        r_k <= r_k + HD_AW'(1);
                    end
                end
                S_TILE: begin
                    r_j     <= r_j0;
                    r_jend  <= jend;
                    r_any   <= 1'b0;
                    r_state <= S_KEY;
                end
                S_KEY: begin
                    if (r_j == r_jend) begin
                        r_state <= S_TMAX;
                    end else if (masked) begin
                        r_j <= r_j + KC_W'(1);
                    end else begin
                        r_dot   <= '0;
                        r_k     <= '0;
                        r_op    <= OP_DOT;
                        r_state <= S_STREAM;
                    end
                end
                S_STREAM: begin
                    if (k_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + HD_AW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        case (r_op)
                            OP_DOT:  r_state <= S_SCORE_M;
                            OP_RESC: r_state <= S_PSTART;
                            default: begin
                                r_j     <= r_j + KC_W'(1);
                                r_state <= S_PKEY;
                            end
                        endcase
                    end
                end
                S_SCORE_M: begin
                    r_state <= S_SCORE_W;
                end
                S_SCORE_W: begin
                    if (!r_any || score > r_tmax) begin
                        r_tmax <= score;
                    end
                    r_any   <= 1'b1;
                    r_j     <= r_j + KC_W'(1);
                    r_state <= S_KEY;
                end
                S_TMAX: begin
                    if (!r_any) begin
                        r_state <= S_NEXT_TILE;
                    end else if (r_tmax > r_max) begin
                        r_x     <= (SCORE_W+1)'(r_max) - (SCORE_W+1)'(r_tmax);
                        r_ret   <= S_RSUM_M;
                        r_state <= S_EXP1;
                    end else begin
                        r_state <= S_PSTART;
                    end
                end
                S_EXP1: begin
                    if (|exp_m[SCORE_W:20]) begin
                        r_e     <= '0;
                        r_state <= r_ret;
                    end else begin
                        r_state <= S_EXP2;
                    end
                end
                S_EXP2: begin
                    if (exp_u[20:16] > 5'd16) begin
                        r_e     <= '0;
                        r_state <= r_ret;
                    end else begin
                        r_en    <= exp_u[20:16];
                        r_eidx  <= exp_u[15:12];
                        r_efr   <= exp_u[11:0];
                        r_state <= S_EXP3;
                    end
                end
                S_EXP3: begin
                    r_state <= S_EXP4;
                end
                S_EXP4: begin
                    r_e     <= exp_val >> r_en;
                    r_state <= r_ret;
                end
                S_RSUM_M: begin
                    r_state <= S_RSUM_W;
                end
                S_RSUM_W: begin
                    r_sum   <= mul_p[FRAC_SH+SUM_W-1:FRAC_SH];
                    r_max   <= r_tmax;
                    r_k     <= '0;
                    r_op    <= OP_RESC;
                    r_state <= S_STREAM;
                end
                S_PSTART: begin
                    r_j     <= r_j0;
                    r_state <= S_PKEY;
                end
                S_PKEY: begin
                    if (r_j == r_jend) begin
                        r_state <= S_NEXT_TILE;
                    end else if (masked) begin
                        r_j <= r_j + KC_W'(1);
                    end else begin
                        r_state <= S_PSCORE;
                    end
                end
                S_PSCORE: begin
                    r_x     <= (SCORE_W+1)'(r_st_rd) - (SCORE_W+1)'(r_max);
                    r_ret   <= S_PACC;
                    r_state <= S_EXP1;
                end
                S_PACC: begin
                    r_sum   <= r_sum + SUM_W'(r_e);
                    r_k     <= '0;
                    r_op    <= OP_PV;
                    r_state <= S_STREAM;
                end
                S_NEXT_TILE: begin
                    if (jsum >= {1'b0, r_kc}) begin
                        r_k     <= '0;
                        r_state <= S_ORD;
                    end else begin
                        r_j0    <= jsum[KC_W-1:0];
                        r_state <= S_TILE;
                    end
                end
                S_ORD: begin
                    r_state <= S_OLAT;
                end
                S_OLAT: begin
                    r_state <= S_ODIV;
                end
                S_ODIV: begin
                    // hold the quotient until the output register is free
                    if (o_load) begin
                        r_ovalid <= 1'b1;
                        r_ocol   <= COL_W'(r_k);
                        r_oval   <= div_rsp.quot;
                        r_olast  <= k_last;
                        if (k_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + HD_AW'(1);
                            r_state <= S_ORD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.out_col   = r_ocol;
    assign o_out.out_value = r_oval;
    assign o_out.out_last  = r_olast;

`ifndef SYNTHESIS
    // Stream pipeline only runs inside a stream or its drain
    a_stream_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_state == S_STREAM || r_state == S_DRAIN))
        else $error("stream pipeline active outside a stream");

    // Key walk never runs past the tile end
    a_key_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KEY || r_state == S_PKEY) |-> (r_j <= r_jend))
        else $error("key index beyond tile end");

    // Divider is idle when a division is started
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OLAT) |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    // Running sum holds at least one term by the output phase
    a_sum_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ODIV) |-> (r_sum != '0))
        else $error("running sum empty at output");
`endif

endmodule

`default_nettype wire

// ===== sim/flash_attention_row_core_tb.sv =====
// Testbench of the flash attention row core: loads query, key and value rows,
// issues compute beats and checks every output element against a local predictor.
// Depends on fa_row_pkg, fa_row_in_if, fa_row_out_if and flash_attention_row_core.
`timescale 1ns / 100ps

module flash_attention_row_core_tb;
    import fa_row_pkg::*;

    typedef struct {
        logic [COL_W-1:0] col;
        logic signed [VAL_W-1:0] value;
        logic last;
    } t_out_elem;

    // Online softmax predictor with its own copy of the stores and registers
    class attn_scoreboard;
        logic signed [VAL_W-1:0] q_row [HEAD_DIM];
        logic signed [VAL_W-1:0] k_mem [MAX_KEYS*HEAD_DIM];
        logic signed [VAL_W-1:0] v_mem [MAX_KEYS*HEAD_DIM];
        int unsigned keys_used, dims_used, mask_on, scale;
        t_out_elem pending[$];
        int errors;

        function void set_defaults();
            keys_used = 256; dims_used = 64; mask_on = 0; scale = 8192; errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_KEY_COUNT:   keys_used = d[KC_W-1:0];
                CFG_HEAD_DIM:    dims_used = d[HD_W-1:0];
                CFG_CAUSAL:      mask_on = d[0];
                CFG_SCORE_SCALE: scale = d;
                default: ;
            endcase
        endfunction

        function longint fdiv(longint x, int s);
            return x >>> s;
        endfunction

        function longint exp_neg(longint x);
            longint u, n, f, ix, fr, t0, t1, tv;
            longint tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                                46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                                32768};
            if (x > 0) x = 0;
            u = ((-x) * 94548) >> 16;
            n = u >> 16;
            if (n > 16) return 0;
            f = u & 'hFFFF; ix = f >> 12; fr = f & 'hFFF;
            t0 = tab[ix]; t1 = tab[ix+1];
            tv = t0 - (((t0 - t1) * fr) >> 12);
            return tv >> n;
        endfunction

        function void note_beat(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                                logic [COL_W-1:0] col, logic signed [VAL_W-1:0] v);
            int unsigned kc, hd, j0, jend;
            longint acc[HEAD_DIM];
            longint score[KEY_TILE];
            longint rmax, tmax, nmax, dot, fct, p, r;
            longint unsigned rsum;
            bit any;
            t_out_elem e;
            case (cmd)
                CMD_LOAD_Q: q_row[col] = v;
                CMD_LOAD_K: k_mem[row*HEAD_DIM+col] = v;
                CMD_LOAD_V: v_mem[row*HEAD_DIM+col] = v;
                default: begin
                    kc = keys_used < 1 ? 1 : (keys_used > MAX_KEYS ? MAX_KEYS : keys_used);
                    hd = dims_used < 1 ? 1 : (dims_used > HEAD_DIM ? HEAD_DIM : dims_used);
                    foreach (acc[k]) acc[k] = 0;
                    rmax = -64'sd2147483648; rsum = 0;
                    for (j0 = 0; j0 < kc; j0 += KEY_TILE) begin
                        jend = (kc - j0 > KEY_TILE) ? j0 + KEY_TILE : kc;
                        any = 0; tmax = -64'sd2147483648;
                        for (int j = j0; j < jend; j++) begin
                            if (mask_on && j > row) continue;
                            dot = 0;
                            for (int k = 0; k < hd; k++)
                                dot += longint'(q_row[k]) * longint'(k_mem[j*HEAD_DIM+k]);
                            score[j-j0] = fdiv(dot * longint'(scale), 24);
                            if (!any || score[j-j0] > tmax) tmax = score[j-j0];
                            any = 1;
                        end
                        if (!any) continue;
                        nmax = tmax > rmax ? tmax : rmax;
                        if (nmax > rmax) begin
                            fct = exp_neg(rmax - nmax);
                            rsum = ((rsum * fct) >> 16) & 'hFFFF_FFFF;
                            for (int k = 0; k < hd; k++) acc[k] = fdiv(acc[k] * fct, 16);
                            rmax = nmax;
                        end
                        for (int j = j0; j < jend; j++) begin
                            if (mask_on && j > row) continue;
                            p = exp_neg(score[j-j0] - rmax);
                            rsum = (rsum + p) & 'hFFFF_FFFF;
                            for (int k = 0; k < hd; k++)
                                acc[k] += p * longint'(v_mem[j*HEAD_DIM+k]);
                        end
                    end
                    for (int k = 0; k < hd; k++) begin
                        r = (rsum != 0) ? acc[k] / longint'(rsum) : 0;
                        if (r > 32767) r = 32767;
                        if (r < -32768) r = -32768;
                        e.col = COL_W'(k); e.value = VAL_W'(r); e.last = (k == hd - 1);
                        pending.push_back(e);
                    end
                end
            endcase
        endfunction

        function void check_elem(logic [COL_W-1:0] col, logic signed [VAL_W-1:0] v,
                                 logic last);
            t_out_elem e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected output col=%0d value=%0d", $time, col, v);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (col !== e.col || v !== e.value || last !== e.last) begin
                $display("%0t: mismatch expected col=%0d value=%0d last=%0d,",
                         $time, e.col, e.value, e.last);
                $display("%0t:          actual col=%0d value=%0d last=%0d",
                         $time, col, v, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    fa_row_in_if in_ch();
    fa_row_out_if out_ch();
    attn_scoreboard attn_sb;
    int idle_cycles;
    bit hold_off;
    int unsigned k_loaded, d_loaded;

    flash_attention_row_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Note accepted beats, check results and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                attn_sb.note_beat(in_ch.cmd, in_ch.row_index, in_ch.col_index, in_ch.in_value);
            if (out_ch.valid && out_ch.ready)
                attn_sb.check_elem(out_ch.out_col, out_ch.out_value, out_ch.out_last);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver: stalls on its own pattern, with a long hold-off on request
    initial begin
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) out_ch.ready <= 0;
            else if (($time / 2000) % 3 == 0) out_ch.ready <= 1;
            else out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_beat(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                             logic [COL_W-1:0] col, logic [VAL_W-1:0] v);
        in_ch.valid <= 1;
        in_ch.cmd <= cmd; in_ch.row_index <= row; in_ch.col_index <= col;
        in_ch.in_value <= v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        // Drop valid for a gap now and then, between bursts
        if ($urandom_range(0, 7) == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        in_ch.valid <= 0;
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 0;
        attn_sb.write_reg(idx, d);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (attn_sb.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] rand_val();
        case ($urandom_range(0, 4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return VAL_W'($urandom_range(0, 16'hFFFF) >> $urandom_range(0, 4)
                            ^ ($urandom_range(0, 1) ? 16'hFFFF : 16'h0));
        endcase
    endfunction

    // Load full query, key and value rows for the first nk keys and nd columns
    task automatic load_set(int unsigned nk, int unsigned nd, bit extreme);
        for (int c = 0; c < nd; c++)
            send_beat(CMD_LOAD_Q, ROW_W'($urandom_range(0, 255)), COL_W'(c),
                      extreme ? 16'h7FFF : rand_val());
        for (int r = 0; r < nk; r++)
            for (int c = 0; c < nd; c++) begin
                send_beat(CMD_LOAD_K, ROW_W'(r), COL_W'(c), extreme ? 16'h8000 : rand_val());
                send_beat(CMD_LOAD_V, ROW_W'(r), COL_W'(c), extreme ? 16'h7FFF : rand_val());
            end
    endtask

    task automatic run_phase(int unsigned nk, int unsigned nd, bit mask,
                             logic [15:0] sc, int ncomp);
        drain();
        write_reg(CFG_KEY_COUNT, CFG_DATA_W'(nk));
        write_reg(CFG_HEAD_DIM, CFG_DATA_W'(nd));
        write_reg(CFG_CAUSAL, CFG_DATA_W'(mask));
        write_reg(CFG_SCORE_SCALE, sc);
        // Reload the whole covered area so that every read entry is written
        if (nk > k_loaded || nd > d_loaded) begin
            k_loaded = nk > k_loaded ? nk : k_loaded;
            d_loaded = nd > d_loaded ? nd : d_loaded;
            load_set(k_loaded, d_loaded, 0);
        end
        for (int i = 0; i < ncomp; i++)
            send_beat(CMD_COMPUTE, ROW_W'($urandom_range(0, 255)),
                      COL_W'($urandom_range(0, 63)), rand_val());
    endtask

    initial begin
        attn_sb = new();
        attn_sb.set_defaults();
        in_ch.valid = 0; in_ch.cmd = CMD_LOAD_Q; in_ch.row_index = 0;
        in_ch.col_index = 0; in_ch.in_value = 0;
        i_cfg_we = 0; i_cfg_idx = CFG_KEY_COUNT; i_cfg_data = 0;
        idle_cycles = 0; hold_off = 0; k_loaded = 0; d_loaded = 0;
        i_rst_n = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: smallest sizes, extreme values
        write_reg(CFG_KEY_COUNT, 1);
        write_reg(CFG_HEAD_DIM, 1);
        write_reg(CFG_CAUSAL, 0);
        write_reg(CFG_SCORE_SCALE, 16'hFFFF);
        load_set(1, 1, 1);
        send_beat(CMD_COMPUTE, 8'd0, 6'd0, 16'h0);
        k_loaded = 1; d_loaded = 1;
        // Key count zero clamps to one; head dim zero clamps to one
        run_phase(0, 0, 0, 0, 1);
        // Causal over two tiles: masked keys and fully masked tiles skipped
        run_phase(17, 2, 1, 16'hFFFF, 2);

        // Pressure: receiver holds off while computes keep coming
        drain();
        fork
            begin
                hold_off = 1;
                repeat (3000) @(negedge i_clk);
                hold_off = 0;
            end
            run_phase(3, 2, 0, 8192, 3);
        join

        // Random phases within the loaded area
        for (int ph = 0; ph < 8; ph++)
            run_phase($urandom_range(1, 17), $urandom_range(1, 2),
                      1'($urandom_range(0, 1)),
                      16'($urandom_range(0, 16'hFFFF)), $urandom_range(2, 5));

        drain();
        if (attn_sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== flash_attention_row_core.f =====
hw/rtl/fa_row_pkg.sv
hw/rtl/fa_row_in_if.sv
hw/rtl/fa_row_out_if.sv
hw/rtl/fa_row_mul.sv
hw/rtl/fa_row_div.sv
hw/rtl/flash_attention_row_core.sv
sim/flash_attention_row_core_tb.sv
